[hw/rtl/hts_pkg.sv]
// Shared types, codes and sizes of the tick task scheduler.
// No dependencies; every other file of the block imports this package.
package hts_pkg;

  localparam int TASK_SLOTS  = 8;
  localparam int TIME_WIDTH  = 16;
  localparam int COUNT_WIDTH = 8;

  // slot index inside the ring
  localparam int IDX_W   = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  // port widths fixed by the item format
  localparam int SEL_W   = 3;
  localparam int TSLOT_W = 4;
  localparam int KIND_W  = 3;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_DELETE   = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PREEMPT  = 3'd0,
    KIND_COOP     = 3'd1,
    KIND_ADD      = 3'd2,
    KIND_DELETE   = 3'd3,
    KIND_TICKDONE = 3'd4,
    KIND_DISPDONE = 3'd5
  } kind_t;

  // one task slot
  typedef struct packed {
    logic                   valid;
    logic                   coop;
    logic [TIME_WIDTH-1:0]  delay;
    logic [TIME_WIDTH-1:0]  period;
    logic [COUNT_WIDTH-1:0] pending;
  } slot_t;

  // latched command item
  typedef struct packed {
    cmd_t                  cmd;
    logic [SEL_W-1:0]      sel;
    logic [TIME_WIDTH-1:0] first_delay;
    logic [TIME_WIDTH-1:0] repeat_period;
    logic                  cooperative;
  } req_t;

  // per-step control handed from the slot updater to the sequencer
  typedef struct packed {
    logic  emit;
    kind_t kind;
    logic  placed;
    logic  hit;
  } upd_res_t;

endpackage

[hw/rtl/hybrid_tick_task_scheduler.sv]
// Top level of the tick task scheduler: command sequencer, slot ring, result register.
// Depends on hts_pkg, hts_cell and hts_upd.
//
// Usage: one command item enters on in_* (tick, add, delete, dispatch). The block
// answers with one or more result items on out_*, the final one with out_last set.
// Run items (pre-emptive at tick, cooperative at dispatch) come in ascending slot
// order, ahead of the completion item.
// The task table sits in a ring of TASK_SLOTS cells. Every command walks the ring
// once: each cycle that the walk is not held, the head slot passes through the
// update unit and re-enters at the tail, so after TASK_SLOTS steps each slot is
// back in its own cell. The done state then loads the completion item, and the
// next command is taken in the cycle after the completion item is loaded.
// in_stall is high while a command is in progress; a finished result may still sit
// in the output register when the next command is accepted.
// When out_stall is high and the output register is full, a walk step that has a
// run item to emit waits; steps with nothing to emit go on.
// Reset (rst_n low, synchronous) empties the table, clears the sticky error and
// drops out_valid; the block is ready in the first cycle after reset.
module hybrid_tick_task_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [hts_pkg::SEL_W-1:0]      in_slot,
  input  logic [hts_pkg::TIME_WIDTH-1:0] in_first_delay,
  input  logic [hts_pkg::TIME_WIDTH-1:0] in_repeat_period,
  input  logic                          in_cooperative,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hts_pkg::KIND_W-1:0]     out_reply_kind,
  output logic [hts_pkg::TSLOT_W-1:0]    out_task_slot,
  output logic                          out_success,
  output logic                          out_error_seen,
  output logic                          out_last
);
  import hts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  req_t             req_r;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] found_idx_r, found_idx_nxt;
  logic             ok_r, ok_nxt;
  logic             error_r, error_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [TSLOT_W-1:0]  out_tslot_r, out_tslot_nxt;
  logic                out_success_r, out_success_nxt;
  logic                out_error_r, out_error_nxt;
  logic                out_last_r, out_last_nxt;

  logic      accept;
  logic      can_load;
  logic      step;
  logic      out_load;
  logic      sel_match;
  slot_t     cell_q [TASK_SLOTS];
  slot_t     cell_d [TASK_SLOTS];
  slot_t     upd_slot;
  upd_res_t  upd_res;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign can_load  = !out_valid_r || !out_stall;
  // the walk holds only when it has a run item and nowhere to put it
  assign step      = (state_r == S_WALK) && (!upd_res.emit || can_load);
  assign sel_match = (32'(idx_r) == 32'(req_r.sel));

  // ---- slot ring: head is cell 0, tail takes the updated head ----
  for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_ring
    if (g == TASK_SLOTS - 1) begin : g_tail
      assign cell_d[g] = upd_slot;
    end else begin : g_body
      assign cell_d[g] = cell_q[g+1];
    end
    hts_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_en(step),
      .d_in    (cell_d[g]),
      .q       (cell_q[g])
    );
  end

  hts_upd u_upd (
    .req      (req_r),
    .cur      (cell_q[0]),
    .sel_match(sel_match),
    .found    (found_r),
    .nxt      (upd_slot),
    .res      (upd_res)
  );

  // ---- sequencer and result register ----
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    found_nxt       = found_r;
    found_idx_nxt   = found_idx_r;
    ok_nxt          = ok_r;
    error_nxt       = error_r;
    out_load        = 1'b0;
    out_kind_nxt    = out_kind_r;
    out_tslot_nxt   = out_tslot_r;
    out_success_nxt = out_success_r;
    out_error_nxt   = out_error_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_WALK;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          ok_nxt    = 1'b0;
        end
      end
      S_WALK: begin
        if (step) begin
          if (upd_res.placed) begin
            found_nxt     = 1'b1;
            found_idx_nxt = idx_r;
          end
          if (upd_res.hit) begin
            ok_nxt = 1'b1;
          end
          if (upd_res.emit) begin
            out_load        = 1'b1;
            out_kind_nxt    = upd_res.kind;
            out_tslot_nxt   = TSLOT_W'(idx_r);
            out_success_nxt = 1'b0;
            out_error_nxt   = error_r;
            out_last_nxt    = 1'b0;
          end
          if (idx_r == LAST_IDX) begin
            idx_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (can_load) begin
          out_load        = 1'b1;
          out_last_nxt    = 1'b1;
          out_tslot_nxt   = '0;
          out_success_nxt = 1'b0;
          state_nxt       = S_IDLE;
          unique case (req_r.cmd)
            CMD_TICK: begin
              out_kind_nxt = KIND_TICKDONE;
            end
            CMD_ADD: begin
              out_kind_nxt    = KIND_ADD;
              out_success_nxt = found_r;
              out_tslot_nxt   = found_r ? TSLOT_W'(found_idx_r) : TSLOT_W'(TASK_SLOTS);
            end
            CMD_DELETE: begin
              out_kind_nxt    = KIND_DELETE;
              out_success_nxt = ok_r;
              out_tslot_nxt   = TSLOT_W'(req_r.sel);
              if (!ok_r) begin
                error_nxt = 1'b1;
              end
            end
            CMD_DISPATCH: begin
              out_kind_nxt = KIND_DISPDONE;
            end
            default: begin
              out_kind_nxt = KIND_TICKDONE;
            end
          endcase
          out_error_nxt = error_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      ok_r        <= 1'b0;
      error_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      ok_r        <= ok_nxt;
      error_r     <= error_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.cmd           <= cmd_t'(in_cmd);
      req_r.sel           <= in_slot;
      req_r.first_delay   <= in_first_delay;
      req_r.repeat_period <= in_repeat_period;
      req_r.cooperative   <= in_cooperative;
    end
    found_idx_r   <= found_idx_nxt;
    out_kind_r    <= out_kind_nxt;
    out_tslot_r   <= out_tslot_nxt;
    out_success_r <= out_success_nxt;
    out_error_r   <= out_error_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_reply_kind = out_kind_r;
  assign out_task_slot  = out_tslot_r;
  assign out_success    = out_success_r;
  assign out_error_seen = out_error_r;
  assign out_last       = out_last_r;

  // ---- assertions ----
  a_accept_walks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_WALK))
    else $error("accepted command did not start a ring walk");

  a_last_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |-> (state_r == S_DONE))
    else $error("completion item loaded outside the done state");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    error_r |=> error_r)
    else $error("sticky error flag dropped");

  a_idle_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (idx_r == '0))
    else $error("ring left unaligned at end of command");

endmodule

[hw/rtl/hts_cell.sv]
// One storage cell of the slot ring: holds a task slot, takes its neighbour's on shift.
// Depends on hts_pkg.
module hts_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  hts_pkg::slot_t d_in,
  output hts_pkg::slot_t q
);
  import hts_pkg::*;

  slot_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

[hw/rtl/hts_upd.sv]
// Slot update unit: applies the current command to the slot at the head of the ring.
// Depends on hts_pkg.
module hts_upd (
  input  hts_pkg::req_t    req,
  input  hts_pkg::slot_t   cur,
  input  logic             sel_match,
  input  logic             found,
  output hts_pkg::slot_t   nxt,
  output hts_pkg::upd_res_t res
);
  import hts_pkg::*;

  slot_t cleared;

  always_comb begin
    cleared         = '0;
    cleared.coop    = cur.coop;   // cooperative mark survives a clear
    nxt             = cur;
    res             = '0;
    res.kind        = KIND_PREEMPT;
    unique case (req.cmd)
      CMD_TICK: begin
        if (cur.valid) begin
          if (cur.delay == '0) begin
            if (!cur.coop) begin
              res.emit = 1'b1;
              res.kind = KIND_PREEMPT;
              if (cur.period == '0) begin
                nxt = cleared;
              end else begin
                nxt.delay = cur.period;
              end
            end else begin
              if (cur.pending != '1) begin
                nxt.pending = cur.pending + 1'b1;
              end
              nxt.delay = cur.period;
            end
          end else begin
            nxt.delay = cur.delay - 1'b1;
          end
        end
      end
      CMD_ADD: begin
        if (!cur.valid && !found) begin
          res.placed  = 1'b1;
          nxt.valid   = 1'b1;
          nxt.delay   = req.first_delay;
          nxt.period  = req.repeat_period;
          nxt.pending = '0;
          nxt.coop    = req.cooperative;
        end
      end
      CMD_DELETE: begin
        if (sel_match) begin
          res.hit = cur.valid;
          nxt     = cleared;
        end
      end
      CMD_DISPATCH: begin
        if (cur.valid && cur.coop && (cur.pending != '0)) begin
          res.emit    = 1'b1;
          res.kind    = KIND_COOP;
          nxt.pending = cur.pending - 1'b1;
          if (cur.period == '0) begin
            nxt = cleared;
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

[tb/sv/hts_sched_chk_pkg.sv]
`timescale 1ns / 100ps
// Reply checker for the tick task scheduler: a mirror of the task table plus the
// queue of reply items still due. Depends on hts_pkg.
package hts_sched_chk_pkg;
  import hts_pkg::*;

  typedef struct {
    kind_t              kind;
    logic [TSLOT_W-1:0] tslot;
    logic               success;
    logic               err;
    logic               last;
  } reply_t;

  class sched_reply_checker;
    slot_t       task_table[TASK_SLOTS];
    bit          err_flag;
    reply_t      replies_due[$];
    int unsigned fails;

    function new();
      foreach (task_table[i]) task_table[i] = '0;
      err_flag = 1'b0;
      fails    = 0;
    endfunction

    // cooperative mark survives a clear
    function void free_slot(int i);
      task_table[i].valid   = 1'b0;
      task_table[i].delay   = '0;
      task_table[i].period  = '0;
      task_table[i].pending = '0;
    endfunction

    function void queue_reply(kind_t kind, int unsigned s, logic ok, logic fin);
      reply_t r;
      r.kind    = kind;
      r.tslot   = TSLOT_W'(s);
      r.success = ok;
      r.err     = err_flag;
      r.last    = fin;
      replies_due.push_back(r);
    endfunction

    function void note_command(cmd_t cmd, logic [SEL_W-1:0] sel,
                               logic [TIME_WIDTH-1:0] first_delay,
                               logic [TIME_WIDTH-1:0] repeat_period, logic coop);
      int   free_idx;
      logic ok;
      free_idx = TASK_SLOTS;
      ok       = 1'b0;
      case (cmd)
        CMD_TICK: begin
          for (int i = 0; i < TASK_SLOTS; i++) begin
            if (!task_table[i].valid) continue;
            if (task_table[i].delay == '0) begin
              if (!task_table[i].coop) begin
                queue_reply(KIND_PREEMPT, i, 1'b0, 1'b0);
                if (task_table[i].period == '0) free_slot(i);
              end else if (task_table[i].pending != '1) begin
                task_table[i].pending = task_table[i].pending + 1'b1;
              end
              if (task_table[i].valid) task_table[i].delay = task_table[i].period;
            end else begin
              task_table[i].delay = task_table[i].delay - 1'b1;
            end
          end
          queue_reply(KIND_TICKDONE, 0, 1'b0, 1'b1);
        end
        CMD_ADD: begin
          for (int i = TASK_SLOTS - 1; i >= 0; i--)
            if (!task_table[i].valid) free_idx = i;
          if (free_idx == TASK_SLOTS) begin
            queue_reply(KIND_ADD, TASK_SLOTS, 1'b0, 1'b1);
          end else begin
            task_table[free_idx].valid   = 1'b1;
            task_table[free_idx].delay   = first_delay;
            task_table[free_idx].period  = repeat_period;
            task_table[free_idx].pending = '0;
            task_table[free_idx].coop    = coop;
            queue_reply(KIND_ADD, free_idx, 1'b1, 1'b1);
          end
        end
        CMD_DELETE: begin
          if (sel < TASK_SLOTS) begin
            ok = task_table[sel].valid;
            free_slot(sel);
          end
          if (!ok) err_flag = 1'b1;
          queue_reply(KIND_DELETE, sel, ok, 1'b1);
        end
        default: begin
          for (int i = 0; i < TASK_SLOTS; i++) begin
            if (task_table[i].valid && task_table[i].coop && task_table[i].pending != '0) begin
              queue_reply(KIND_COOP, i, 1'b0, 1'b0);
              task_table[i].pending = task_table[i].pending - 1'b1;
              if (task_table[i].period == '0) free_slot(i);
            end
          end
          queue_reply(KIND_DISPDONE, 0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    task report(string msg);
      if (fails < 100) $display("%0t: reply mismatch: %s", $time, msg);
      fails++;
    endtask

    task check_reply(logic [KIND_W-1:0] kind, logic [TSLOT_W-1:0] tslot,
                     logic success, logic err, logic last);
      reply_t exp;
      if (replies_due.size() == 0) begin
        report($sformatf("unexpected item, kind %0d slot %0d", kind, tslot));
        return;
      end
      exp = replies_due.pop_front();
      if (kind !== exp.kind)
        report($sformatf("kind expected %0d got %0d", exp.kind, kind));
      if (tslot !== exp.tslot)
        report($sformatf("kind %0d: slot expected %0d got %0d", exp.kind, exp.tslot, tslot));
      if (success !== exp.success)
        report($sformatf("kind %0d slot %0d: success expected %0d got %0d",
                         exp.kind, exp.tslot, exp.success, success));
      if (err !== exp.err)
        report($sformatf("kind %0d slot %0d: error flag expected %0d got %0d",
                         exp.kind, exp.tslot, exp.err, err));
      if (last !== exp.last)
        report($sformatf("kind %0d slot %0d: last expected %0d got %0d",
                         exp.kind, exp.tslot, exp.last, last));
    endtask
  endclass

endpackage

[tb/sv/tb_hybrid_tick_task_scheduler.sv]
`timescale 1ns / 100ps
// Testbench top for hybrid_tick_task_scheduler: clock, reset, command driver,
// result stall pattern and checker hookup. Depends on hts_pkg, hts_sched_chk_pkg, RTL.
module tb_hybrid_tick_task_scheduler;
  import hts_pkg::*;
  import hts_sched_chk_pkg::*;

  // generous bound: ~330 items, each at worst nine results behind a long stall
  localparam int TIMEOUT_NS    = 5_000_000;
  // settle time of four walk lengths, to catch stray items
  localparam int SETTLE_CYCLES = 4 * (TASK_SLOTS + 1);
  localparam int RANDOM_ITEMS  = 40;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_BURST
  } stall_mode_t;

  logic                   clk;
  logic                   rst_n            = 1'b0;
  logic                   in_valid         = 1'b0;
  logic                   in_stall;
  logic [1:0]             in_cmd           = CMD_TICK;
  logic [SEL_W-1:0]       in_slot          = '0;
  logic [TIME_WIDTH-1:0]  in_first_delay   = '0;
  logic [TIME_WIDTH-1:0]  in_repeat_period = '0;
  logic                   in_cooperative   = 1'b0;
  logic                   out_valid;
  logic                   out_stall        = 1'b0;
  logic [KIND_W-1:0]      out_reply_kind;
  logic [TSLOT_W-1:0]     out_task_slot;
  logic                   out_success;
  logic                   out_error_seen;
  logic                   out_last;

  sched_reply_checker     chk = new();

  // sender burst pacing
  int unsigned            burst_left   = 0;
  // receiver stall pattern
  stall_mode_t            stall_mode   = STALL_NONE;
  int unsigned            mode_cycles  = 0;
  int unsigned            burst_cycles = 0;

  hybrid_tick_task_scheduler u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_slot          (in_slot),
    .in_first_delay   (in_first_delay),
    .in_repeat_period (in_repeat_period),
    .in_cooperative   (in_cooperative),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reply_kind   (out_reply_kind),
    .out_task_slot    (out_task_slot),
    .out_success      (out_success),
    .out_error_seen   (out_error_seen),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  // Result side: values read straight after the edge are the pre-edge ones,
  // i.e. what the block itself saw, so the handshake view matches the RTL.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      chk.check_reply(out_reply_kind, out_task_slot, out_success, out_error_seen, out_last);
  end

  // Receiver stall pattern: switches at random between no stall, a random stall
  // (probability 0.4) and on/off bursts of random length.
  always @(posedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  <= stall_mode_t'($urandom_range(0, 2));
      mode_cycles <= $urandom_range(50, 300);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 9) < 4);
      STALL_BURST: begin
        if (burst_cycles == 0) begin
          out_stall    <= !out_stall;
          burst_cycles <= $urandom_range(0, 7);
        end else begin
          burst_cycles <= burst_cycles - 1;
        end
      end
      default:      out_stall <= 1'b0;
    endcase
  end

  task automatic idle(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every reply due has come back; the wait takes a clock edge before
  // it checks, so valid is never lowered and raised in the same step.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.replies_due.size() != 0);
  endtask

  // Present one command item, wait for its acceptance, note it, then pace the
  // sender: bursts of up to 11 back-to-back items, mostly followed by a gap.
  task automatic send_command(cmd_t cmd, logic [SEL_W-1:0] sel,
                              logic [TIME_WIDTH-1:0] first_delay,
                              logic [TIME_WIDTH-1:0] repeat_period, logic coop);
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_slot          <= sel;
    in_first_delay   <= first_delay;
    in_repeat_period <= repeat_period;
    in_cooperative   <= coop;
    do @(posedge clk); while (in_stall !== 1'b0);
    chk.note_command(cmd, sel, first_delay, repeat_period, coop);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 10);
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
    end
  endtask

  // Mostly tiny times so tasks fall due often; now and then a full-width value.
  function automatic logic [TIME_WIDTH-1:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return TIME_WIDTH'($urandom);
    if (r < 30) return TIME_WIDTH'($urandom_range(4, 20));
    return TIME_WIDTH'($urandom_range(0, 3));
  endfunction

  initial begin
    int unsigned r;
    cmd_t        cmd;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: empty table, every kind of task, full table, deletes ---
    send_command(CMD_TICK,     3'd0, '0, '0, 1'b0);       // tick on empty table
    send_command(CMD_DISPATCH, 3'd0, '0, '0, 1'b0);       // nothing to dispatch
    send_command(CMD_ADD,      3'd0, '0, '0, 1'b0);       // pre-emptive one-shot, due now
    send_command(CMD_ADD,      3'd0, '0, '0, 1'b1);       // coop one-shot, due every tick
    send_command(CMD_ADD,      3'd0, 16'd1, 16'd1, 1'b0);
    send_command(CMD_ADD,      3'd0, '1, '1, 1'b1);       // longest delay and period
    send_command(CMD_ADD,      3'd0, '1, '0, 1'b0);
    send_command(CMD_ADD,      3'd0, 16'd2, 16'd3, 1'b1);
    send_command(CMD_ADD,      3'd0, '0, '1, 1'b0);
    send_command(CMD_ADD,      3'd0, 16'd1, '0, 1'b1);
    send_command(CMD_ADD,      3'd5, 16'd7, 16'd7, 1'b1); // table full
    send_command(CMD_TICK,     3'd0, '0, '0, 1'b0);
    send_command(CMD_TICK,     3'd0, '0, '0, 1'b0);
    send_command(CMD_DISPATCH, 3'd0, '0, '0, 1'b0);
    send_command(CMD_TICK,     3'd0, '0, '0, 1'b0);
    send_command(CMD_TICK,     3'd0, '0, '0, 1'b0);
    send_command(CMD_DISPATCH, 3'd0, '0, '0, 1'b0);
    send_command(CMD_DELETE,   3'd3, '0, '0, 1'b0);       // occupied slot
    send_command(CMD_DELETE,   3'd0, '1, '1, 1'b1);       // empty slot: sticky error
    send_command(CMD_DELETE,   3'd7, '0, '0, 1'b0);       // top slot
    send_command(CMD_ADD,      3'd7, 16'd0, 16'd2, 1'b0); // refills lowest free slot
    send_command(CMD_TICK,     3'd7, '1, '1, 1'b1);       // unused fields high
    drain();

    // --- pending count saturation: coop one-shot left undispatched ---
    for (int i = 0; i < TASK_SLOTS; i++)
      send_command(CMD_DELETE, SEL_W'(i), '0, '0, 1'b0);
    send_command(CMD_ADD, 3'd0, '0, '0, 1'b1);
    repeat ((1 << COUNT_WIDTH) + 2)
      send_command(CMD_TICK, 3'd0, '0, '0, 1'b0);
    send_command(CMD_DISPATCH, 3'd0, '0, '0, 1'b0);
    send_command(CMD_DISPATCH, 3'd0, '0, '0, 1'b0);
    drain();

    // --- random mix: ticks dominate so tasks keep falling due ---
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      cmd = CMD_TICK;
      else if (r < 65) cmd = CMD_ADD;
      else if (r < 80) cmd = CMD_DELETE;
      else             cmd = CMD_DISPATCH;
      send_command(cmd, SEL_W'($urandom), pick_time(), pick_time(), 1'($urandom));
      if ($urandom_range(0, 19) == 0) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (chk.fails == 0 && chk.replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[hybrid_tick_task_scheduler.f]
hw/rtl/hts_pkg.sv
hw/rtl/hts_cell.sv
hw/rtl/hts_upd.sv
hw/rtl/hybrid_tick_task_scheduler.sv
tb/sv/hts_sched_chk_pkg.sv
tb/sv/tb_hybrid_tick_task_scheduler.sv
